@@ sv/stepper_and_led_pwm_tick_driver_defines.svh @@
// Assertion macros shared by the checker of the stepper and LED tick driver.
// Needs a clock named clk and an active-high reset named rst in scope.
`ifndef STEPPER_AND_LED_PWM_TICK_DRIVER_DEFINES_SVH
`define STEPPER_AND_LED_PWM_TICK_DRIVER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SLDRV_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SLDRV_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/sldrv_pkg.sv @@
// Shared types, codes and constants for the stepper and LED tick driver.
// No dependencies; every other RTL file imports this package.
`default_nettype none

package sldrv_pkg;

  localparam int NUM_MOTORS  = 3;
  localparam int PHASE_COUNT = 8;

  localparam int PHASE_W  = 3;
  localparam int SPEED_W  = 10;
  localparam int STEPS_W  = 32;
  localparam int PRESC_W  = 11;
  localparam int LEVEL_W  = 8;
  localparam int SEL_W    = 2;
  localparam int DIR_W    = 2;
  localparam int REQ_W    = 2;
  localparam int IN_DW    = 80;
  localparam int OUT_DW   = 24;

  localparam logic [PHASE_W-1:0] LAST_PHASE = PHASE_W'(PHASE_COUNT - 1);
  localparam logic [SPEED_W-1:0] RESET_RELOAD = SPEED_W'(10);

  // Half-step coil patterns, upper nibble
  localparam logic [7:0] COIL_TABLE [8] = '{
    8'h10, 8'h30, 8'h20, 8'h60, 8'h40, 8'hC0, 8'h80, 8'h90
  };

  localparam logic [7:0] GRAB_IR_BIT = 8'h08;

  typedef enum logic [REQ_W-1:0] {
    REQ_TICK  = 2'd0,
    REQ_MOTOR = 2'd1,
    REQ_LED   = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  // Normalized direction codes
  localparam logic [DIR_W-1:0] DIR_HOLD = 2'b00;
  localparam logic [DIR_W-1:0] DIR_FWD  = 2'b01;
  localparam logic [DIR_W-1:0] DIR_REV  = 2'b11;

  typedef struct packed {
    logic               tick;
    logic               cmd;
    logic [DIR_W-1:0]   dir;
    logic               load_speed;
    logic [SPEED_W-1:0] speed;
    logic [STEPS_W-1:0] steps;
  } motor_ctl_t;

  typedef struct packed {
    logic       running;
    logic [7:0] coil;
  } motor_stat_t;

  typedef struct packed {
    logic               tick;
    logic               set;
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] blue;
    logic               line_ir;
    logic               grab_ir;
  } led_ctl_t;

  typedef struct packed {
    logic red_on;
    logic green_on;
    logic blue_on;
    logic line_ir;
    logic grab_ir;
  } led_stat_t;

endpackage

`default_nettype wire

@@ sv/sldrv_motor.sv @@
// One stepper channel: direction, period, prescaler, step count and phase.
// Depends on sldrv_pkg.
`default_nettype none

module sldrv_motor (
  input  wire                   clk,
  input  wire                   rst,
  input  sldrv_pkg::motor_ctl_t ctl,
  output sldrv_pkg::motor_stat_t stat
);
  import sldrv_pkg::*;

  logic [DIR_W-1:0]   dir, dir_next;
  logic [SPEED_W-1:0] reload, reload_next;
  logic [PRESC_W-1:0] presc, presc_next;
  logic [STEPS_W-1:0] steps, steps_next;
  logic               running, running_next;
  logic [PHASE_W-1:0] phase, phase_next;

  always_comb begin
    dir_next     = dir;
    reload_next  = reload;
    presc_next   = presc;
    steps_next   = steps;
    running_next = running;
    phase_next   = phase;
    if (ctl.cmd) begin
      if (ctl.dir == DIR_FWD || ctl.dir == DIR_HOLD) begin
        dir_next = ctl.dir;
      end else begin
        dir_next = DIR_REV;
      end
      if (ctl.load_speed) begin
        reload_next = ctl.speed;
      end
      steps_next = ctl.steps;
      if (ctl.steps != '0) begin
        running_next = 1'b1;
        presc_next   = {1'b0, reload_next};
      end else begin
        running_next = 1'b0;
        presc_next   = '1;
      end
    end else if (ctl.tick) begin
      if (steps[STEPS_W-1:1] != '0) begin
        if (presc == '0) begin
          if (dir == DIR_FWD) begin
            phase_next = (phase >= LAST_PHASE) ? '0 : phase + 1'b1;
          end else if (dir == DIR_REV) begin
            phase_next = (phase == '0) ? LAST_PHASE : phase - 1'b1;
          end
          // all ones means run forever
          if (steps != '1) begin
            steps_next = steps - 1'b1;
          end
          presc_next = {1'b0, reload};
        end else begin
          presc_next = presc - 1'b1;
        end
      end else begin
        steps_next   = '0;
        running_next = 1'b0;
        phase_next   = '0;
        presc_next   = '1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dir     <= DIR_HOLD;
      reload  <= RESET_RELOAD;
      presc   <= '1;
      steps   <= '0;
      running <= 1'b0;
      phase   <= '0;
    end else begin
      dir     <= dir_next;
      reload  <= reload_next;
      presc   <= presc_next;
      steps   <= steps_next;
      running <= running_next;
      phase   <= phase_next;
    end
  end

  // Stopped coils drive zero
  assign stat.running = running_next;
  assign stat.coil    = running_next ? COIL_TABLE[phase_next] : 8'h00;

endmodule

`default_nettype wire

@@ sv/sldrv_led_pwm.sv @@
// RGB LED duty levels, 256-step PWM phase counter and IR emitter enables.
// Depends on sldrv_pkg.
`default_nettype none

module sldrv_led_pwm (
  input  wire                 clk,
  input  wire                 rst,
  input  sldrv_pkg::led_ctl_t ctl,
  output sldrv_pkg::led_stat_t stat
);
  import sldrv_pkg::*;

  logic [LEVEL_W-1:0] red_level, green_level, blue_level;
  logic [LEVEL_W-1:0] pwm_phase;
  logic [1:0]         ir_enables;

  always_ff @(posedge clk) begin
    if (rst) begin
      red_level   <= '0;
      green_level <= '0;
      blue_level  <= '0;
      pwm_phase   <= '0;
      ir_enables  <= '0;
    end else begin
      if (ctl.set) begin
        red_level   <= ctl.red;
        green_level <= ctl.green;
        blue_level  <= ctl.blue;
        ir_enables  <= {ctl.grab_ir, ctl.line_ir};
      end
      if (ctl.tick) begin
        pwm_phase <= pwm_phase + 1'b1;
      end
    end
  end

  // Compare against the phase before it advances
  assign stat.red_on   = pwm_phase < red_level;
  assign stat.green_on = pwm_phase < green_level;
  assign stat.blue_on  = pwm_phase < blue_level;
  assign stat.line_ir  = ir_enables[0];
  assign stat.grab_ir  = ir_enables[1];

endmodule

`default_nettype wire

@@ sv/stepper_and_led_pwm_tick_driver.sv @@
// Result path: a tick item's result passes through the input register, then the
//   result register, and shows on the master side from there; other items give
//   no result.
// Throughput: one item per cycle; input stalls only while a tick sits in the
//   input register and the result register holds an item not yet taken.
// Reset: synchronous, active high; motors stop, LED levels, PWM phase and IR clear.
`default_nettype none

module stepper_and_led_pwm_tick_driver (
  input  wire                           clk,
  input  wire                           rst,
  // slave side
  input  wire                           s_tvalid,
  output logic                          s_tready,
  // [1:0] motor_sel, [3:2] direction, [4] load_speed, [14:5] speed_reload,
  // [46:15] step_count, [54:47] red_level, [62:55] green_level,
  // [70:63] blue_level, [71] line_ir_on, [72] grab_ir_on, [79:73] zero
  input  wire  [sldrv_pkg::IN_DW-1:0]   s_tdata,
  // [1:0] req_type
  input  wire  [sldrv_pkg::REQ_W-1:0]   s_tuser,
  // master side
  output logic                          m_tvalid,
  input  wire                           m_tready,
  // [7:0] coil_byte_high, [15:8] coil_byte_low, [16] red_on, [17] green_on,
  // [18] blue_on, [19] line_ir_led, [22:20] motors_running, [23] zero
  output logic [sldrv_pkg::OUT_DW-1:0]  m_tdata
);
  import sldrv_pkg::*;

  // Input register: hold one item until the processing step takes it
  logic               in_valid;
  req_t               in_req;
  logic [IN_DW-1:0]   in_data;

  // Result register
  logic               out_valid;
  logic [OUT_DW-1:0]  out_data;

  logic proc_go;
  logic do_tick;
  logic do_motor;
  logic do_led;

  // A tick needs the result register free or being taken; other requests always drain
  assign proc_go  = in_valid && (in_req != REQ_TICK || !out_valid || m_tready);
  assign do_tick  = proc_go && in_req == REQ_TICK;
  assign do_motor = proc_go && in_req == REQ_MOTOR;
  assign do_led   = proc_go && in_req == REQ_LED;
  assign s_tready = !in_valid || proc_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_req  <= req_t'(s_tuser);
      in_data <= s_tdata;
    end
  end

  // Unpack the held item
  logic [SEL_W-1:0]   f_sel;
  logic [DIR_W-1:0]   f_dir;
  logic               f_load;
  logic [SPEED_W-1:0] f_speed;
  logic [STEPS_W-1:0] f_steps;

  assign f_sel   = in_data[1:0];
  assign f_dir   = in_data[3:2];
  assign f_load  = in_data[4];
  assign f_speed = in_data[14:5];
  assign f_steps = in_data[46:15];

  // Motor channels, updated in parallel
  motor_stat_t mstat [NUM_MOTORS];

  for (genvar m = 0; m < NUM_MOTORS; m++) begin : g_motor
    motor_ctl_t mctl;
    always_comb begin
      mctl.tick       = do_tick;
      // selects past the last motor match nothing and are dropped
      mctl.cmd        = do_motor && ({1'b0, f_sel} == 3'(m));
      mctl.dir        = f_dir;
      mctl.load_speed = f_load;
      mctl.speed      = f_speed;
      mctl.steps      = f_steps;
    end
    sldrv_motor u_motor (
      .clk  (clk),
      .rst  (rst),
      .ctl  (mctl),
      .stat (mstat[m])
    );
  end

  // Only the first three motors reach the output; absent ones read as stopped
  logic [7:0] coil [3];
  logic [2:0] run_bits;

  for (genvar i = 0; i < 3; i++) begin : g_view
    if (i < NUM_MOTORS) begin : g_on
      assign coil[i]     = mstat[i].coil;
      assign run_bits[i] = mstat[i].running;
    end else begin : g_off
      assign coil[i]     = 8'h00;
      assign run_bits[i] = 1'b0;
    end
  end

  // LED PWM and IR enables
  led_ctl_t  lctl;
  led_stat_t lstat;

  always_comb begin
    lctl.tick    = do_tick;
    lctl.set     = do_led;
    lctl.red     = in_data[54:47];
    lctl.green   = in_data[62:55];
    lctl.blue    = in_data[70:63];
    lctl.line_ir = in_data[71];
    lctl.grab_ir = in_data[72];
  end

  sldrv_led_pwm u_led (
    .clk  (clk),
    .rst  (rst),
    .ctl  (lctl),
    .stat (lstat)
  );

  // Assemble the tick result
  logic [7:0]        coil_hi;
  logic [7:0]        coil_lo;
  logic [OUT_DW-1:0] result;

  assign coil_hi = coil[0] | (lstat.grab_ir ? GRAB_IR_BIT : 8'h00);
  assign coil_lo = (coil[1] >> 4) | coil[2];
  assign result  = {1'b0, run_bits, lstat.line_ir, lstat.blue_on, lstat.green_on,
                    lstat.red_on, coil_lo, coil_hi};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (do_tick) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_tick) begin
      out_data <= result;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

endmodule

`default_nettype wire

@@ sv/sldrv_checker.sv @@
// Port-level checks for the stepper and LED tick driver, bound to the top level.
// Depends on sldrv_pkg and the assertion macros header.
`default_nettype none

`include "stepper_and_led_pwm_tick_driver_defines.svh"

module sldrv_checker (
  input wire                          clk,
  input wire                          rst,
  input wire                          s_tready,
  input wire                          m_tvalid,
  input wire                          m_tready,
  input wire [sldrv_pkg::OUT_DW-1:0]  m_tdata
);
  import sldrv_pkg::*;

  // stalled result holds
  `SLDRV_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

  // input only backs up behind a stalled result
  `SLDRV_ASSERT_NOW(a_ready, !s_tready, m_tvalid && !m_tready, "input stalled with output free")

  // a running motor drives a nonzero nibble, a stopped one drives zero
  `SLDRV_ASSERT_NOW(a_coil_left, m_tvalid, m_tdata[20] == (m_tdata[7:4] != 4'h0), "left coil vs running")

  `SLDRV_ASSERT_NOW(a_coil_rest, m_tvalid, (m_tdata[21] == (m_tdata[11:8] != 4'h0)) && (m_tdata[22] == (m_tdata[15:12] != 4'h0)), "right or gripper coil vs running")

endmodule

bind stepper_and_led_pwm_tick_driver sldrv_checker u_sldrv_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
